// ----- src/hbs_pkg.sv -----
// Shared types and constants of the heightmap bilinear sampler.
package hbs_pkg;

	localparam int DIM_W    = 9;
	localparam int COORD_W  = 17;
	localparam int FRAC_W   = 16;
	localparam int SAMPLE_W = 16;
	localparam int SCALE_W  = 16;
	localparam int HV_W     = 24;

	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 8;

	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	localparam logic signed [HV_W:0] HV_MAX = 25'sd8388607;
	localparam logic signed [HV_W:0] HV_MIN = -25'sd8388608;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_WRITE,
		OP_SAMPLE
	} op_t;

	typedef enum logic [1:0] {
		REG_MAP_WIDTH,
		REG_MAP_HEIGHT,
		REG_HEIGHT_SCALE,
		REG_HEIGHT_OFFSET
	} cfg_reg_t;

	typedef struct packed {
		logic                func;
		logic [7:0]          col;
		logic [7:0]          row;
		logic [SAMPLE_W-1:0] sample;
		logic [COORD_W-1:0]  u;
		logic [COORD_W-1:0]  v;
	} in_item_t;

	typedef struct packed {
		logic signed [HV_W-1:0] height_value;
		logic                   saturated;
	} out_item_t;

	typedef struct packed {
		op_t                 op;
		logic [DIM_W-1:0]    xa;
		logic [DIM_W-1:0]    xb;
		logic [DIM_W-1:0]    ya;
		logic [DIM_W-1:0]    yb;
		logic [FRAC_W-1:0]   fx;
		logic [FRAC_W-1:0]   fy;
		logic [SAMPLE_W-1:0] sample;
	} cmd_t;

endpackage

// ----- src/hbs_fifo.sv -----
// Small register queue; the writer guarantees room by credits.
module hbs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_pop;

	assign empty   = (count_q == '0);
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ----- src/hbs_front.sv -----
// Front end: accepts items, scales coordinates, clamps cells and classifies commands.
module hbs_front import hbs_pkg::*; #(
	parameter int MAX_COLS = 256,
	parameter int MAX_ROWS = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  in_item_t         in_item,
	input  logic [DIM_W-1:0] map_width,
	input  logic [DIM_W-1:0] map_height,
	input  logic             issue,
	output logic             cmd_valid,
	output cmd_t             cmd
);

	localparam int COL_CAP = (MAX_COLS > 511) ? 511 : MAX_COLS;
	localparam int ROW_CAP = (MAX_ROWS > 511) ? 511 : MAX_ROWS;
	localparam int SCW = COORD_W + DIM_W;
	localparam int OCCW = $clog2(MID_DEPTH + 1);

	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;
	logic [DIM_W-1:0] wm1;
	logic [DIM_W-1:0] hm1;
	logic             accept;
	logic [OCCW-1:0]  occ_q;

	logic             v_s1;
	in_item_t         item_s1;
	logic [SCW-1:0]   xs;
	logic [SCW-1:0]   ys;

	logic             v_s2;
	logic             func_s2;
	logic [7:0]       col_s2;
	logic [7:0]       row_s2;
	logic [15:0]      sample_s2;
	logic [SCW-1:0]   xs_s2;
	logic [SCW-1:0]   ys_s2;

	logic [DIM_W:0]   xc;
	logic [DIM_W:0]   yc;
	logic [DIM_W-1:0] xa;
	logic [DIM_W-1:0] ya;
	logic [DIM_W:0]   xa1;
	logic [DIM_W:0]   ya1;

	always_comb begin
		if (map_width == '0) begin
			w_eff = DIM_W'(1);
		end else if (32'(map_width) > COL_CAP) begin
			w_eff = DIM_W'(COL_CAP);
		end else begin
			w_eff = map_width;
		end
		if (map_height == '0) begin
			h_eff = DIM_W'(1);
		end else if (32'(map_height) > ROW_CAP) begin
			h_eff = DIM_W'(ROW_CAP);
		end else begin
			h_eff = map_height;
		end
		wm1 = w_eff - 1'b1;
		hm1 = h_eff - 1'b1;
	end

	assign full   = (32'(occ_q) == MID_DEPTH);
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			if (accept && !issue) begin
				occ_q <= occ_q + 1'b1;
			end else if (!accept && issue) begin
				occ_q <= occ_q - 1'b1;
			end
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	assign xs = SCW'(item_s1.u) * SCW'(wm1);
	assign ys = SCW'(item_s1.v) * SCW'(hm1);

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
		func_s2   <= item_s1.func;
		col_s2    <= item_s1.col;
		row_s2    <= item_s1.row;
		sample_s2 <= item_s1.sample;
		xs_s2     <= xs;
		ys_s2     <= ys;
	end

	always_comb begin
		xc  = xs_s2[SCW-1:FRAC_W];
		yc  = ys_s2[SCW-1:FRAC_W];
		xa  = (xc > {1'b0, wm1}) ? wm1 : xc[DIM_W-1:0];
		ya  = (yc > {1'b0, hm1}) ? hm1 : yc[DIM_W-1:0];
		xa1 = {1'b0, xa} + 1'b1;
		ya1 = {1'b0, ya} + 1'b1;

		cmd        = '0;
		cmd.sample = sample_s2;
		if (func_s2 == FUNC_SAMPLE) begin
			cmd.op = OP_SAMPLE;
			cmd.xa = xa;
			cmd.ya = ya;
			cmd.xb = (xa1 > {1'b0, wm1}) ? wm1 : xa1[DIM_W-1:0];
			cmd.yb = (ya1 > {1'b0, hm1}) ? hm1 : ya1[DIM_W-1:0];
			cmd.fx = xs_s2[FRAC_W-1:0];
			cmd.fy = ys_s2[FRAC_W-1:0];
		end else begin
			// drop writes that fall outside the storage
			cmd.op = (32'(col_s2) < MAX_COLS && 32'(row_s2) < MAX_ROWS) ? OP_WRITE : OP_NOP;
			cmd.xa = DIM_W'(col_s2);
			cmd.xb = DIM_W'(col_s2);
			cmd.ya = DIM_W'(row_s2);
			cmd.yb = DIM_W'(row_s2);
		end
	end

	assign cmd_valid = v_s2;

endmodule

// ----- src/hbs_back.sv -----
// Back end: 2x2 interleaved height banks, bilinear blend, scale, offset and result queue.
module hbs_back import hbs_pkg::*; #(
	parameter int MAX_COLS = 256,
	parameter int MAX_ROWS = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_empty,
	input  cmd_t                      cmd,
	output logic                      cmd_pop,
	input  logic signed [SCALE_W-1:0] height_scale,
	input  logic signed [SCALE_W-1:0] height_offset,
	output logic                      empty,
	input  logic                      pop,
	output out_item_t                 out_item
);

	localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int HCW = (CW > 1) ? CW - 1 : 1;
	localparam int HRW = (RW > 1) ? RW - 1 : 1;
	localparam int AW  = HCW + HRW;
	localparam int BANK_DEPTH = 1 << AW;
	localparam int RESVW = $clog2(OUT_DEPTH + 1);

	logic             issue;
	logic [RESVW-1:0] resv_q;
	logic             out_take;
	logic [3:0]       we;
	logic [AW-1:0]    addr [4];
	logic [DIM_W-1:0] bcol [4];
	logic [DIM_W-1:0] brow [4];

	logic [3:0][SAMPLE_W-1:0] rd_s1;
	logic                     v_s1;
	logic [1:0]               sel11_s1;
	logic [1:0]               sel21_s1;
	logic [1:0]               sel12_s1;
	logic [1:0]               sel22_s1;
	logic [FRAC_W-1:0]        fx_s1;
	logic [FRAC_W-1:0]        fy_s1;

	logic signed [16:0] dx1;
	logic signed [16:0] dx2;
	logic signed [16:0] fxs;
	logic signed [33:0] px1;
	logic signed [33:0] px2;

	logic              v_s2;
	logic [31:0]       hx1_s2;
	logic [31:0]       hx2_s2;
	logic [FRAC_W-1:0] fy_s2;

	logic signed [32:0] dy;
	logic signed [16:0] fys;
	logic signed [49:0] py;

	logic        v_s3;
	logic [47:0] hh_s3;

	logic signed [40:0] plo;
	logic signed [40:0] phi;
	logic               v_s4;
	logic signed [40:0] plo_s4;
	logic signed [40:0] phi_s4;

	logic signed [63:0]   prod;
	logic signed [HV_W:0] q;
	out_item_t            res;

	assign issue   = !cmd_empty && (cmd.op != OP_SAMPLE || 32'(resv_q) < OUT_DEPTH);
	assign cmd_pop = issue;
	assign out_take = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resv_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
		end else begin
			if ((issue && cmd.op == OP_SAMPLE) && !out_take) begin
				resv_q <= resv_q + 1'b1;
			end else if (!(issue && cmd.op == OP_SAMPLE) && out_take) begin
				resv_q <= resv_q - 1'b1;
			end
			v_s1 <= issue && cmd.op == OP_SAMPLE;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// bank index is {row parity, column parity}
	always_comb begin
		for (int b = 0; b < 4; b++) begin
			bcol[b] = (cmd.xa[0] == 1'(b)) ? cmd.xa : cmd.xb;
			brow[b] = (cmd.ya[0] == 1'(b >> 1)) ? cmd.ya : cmd.yb;
			addr[b] = {HRW'(brow[b] >> 1), HCW'(bcol[b] >> 1)};
			we[b]   = issue && cmd.op == OP_WRITE &&
			          cmd.xa[0] == 1'(b) && cmd.ya[0] == 1'(b >> 1);
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_bank
		logic [SAMPLE_W-1:0] mem [BANK_DEPTH];

		always_ff @(posedge clk) begin
			if (we[g]) begin
				mem[addr[g]] <= cmd.sample;
			end
			rd_s1[g] <= mem[addr[g]];
		end
	end

	always_ff @(posedge clk) begin
		sel11_s1 <= {cmd.ya[0], cmd.xa[0]};
		sel21_s1 <= {cmd.ya[0], cmd.xb[0]};
		sel12_s1 <= {cmd.yb[0], cmd.xa[0]};
		sel22_s1 <= {cmd.yb[0], cmd.xb[0]};
		fx_s1    <= cmd.fx;
		fy_s1    <= cmd.fy;
	end

	always_comb begin
		fxs = $signed({1'b0, fx_s1});
		dx1 = $signed({1'b0, rd_s1[sel21_s1]}) - $signed({1'b0, rd_s1[sel11_s1]});
		dx2 = $signed({1'b0, rd_s1[sel22_s1]}) - $signed({1'b0, rd_s1[sel12_s1]});
		px1 = dx1 * fxs;
		px2 = dx2 * fxs;
	end

	always_ff @(posedge clk) begin
		hx1_s2 <= 32'($signed({2'b00, rd_s1[sel11_s1], 16'h0000}) + px1);
		hx2_s2 <= 32'($signed({2'b00, rd_s1[sel12_s1], 16'h0000}) + px2);
		fy_s2  <= fy_s1;
	end

	always_comb begin
		fys = $signed({1'b0, fy_s2});
		dy  = $signed({1'b0, hx2_s2}) - $signed({1'b0, hx1_s2});
		py  = dy * fys;
	end

	always_ff @(posedge clk) begin
		hh_s3 <= 48'($signed({2'b00, hx1_s2, 16'h0000}) + py);
	end

	// split the 48 x 16 scale product into two partial products
	always_comb begin
		plo = $signed({1'b0, hh_s3[23:0]}) * height_scale;
		phi = $signed({1'b0, hh_s3[47:24]}) * height_scale;
	end

	always_ff @(posedge clk) begin
		plo_s4 <= plo;
		phi_s4 <= phi;
	end

	always_comb begin
		prod = (64'(phi_s4) <<< 24) + 64'(plo_s4) + 64'sh0000_8000_0000_0000;
		q    = (HV_W + 1)'($signed(prod[63:48])) + (HV_W + 1)'(height_offset);
		res.saturated = 1'b0;
		if (q > HV_MAX) begin
			res.height_value = HV_W'(HV_MAX);
			res.saturated    = 1'b1;
		end else if (q < HV_MIN) begin
			res.height_value = HV_W'(HV_MIN);
			res.saturated    = 1'b1;
		end else begin
			res.height_value = HV_W'(q);
		end
	end

	hbs_fifo #(
		.WIDTH ($bits(out_item_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (v_s4),
		.wr_data (res),
		.pop     (pop),
		.rd_data (out_item),
		.empty   (empty)
	);

endmodule

// ----- src/heightmap_bilinear_sampler_top.sv -----
// Heightmap bilinear sampler top level: configuration registers, front end, command queue, back end.
//
// Takes one item per clock cycle while full is low, for writes and samples alike. The
// grid sits in four banks interleaved by column and row parity, so the four
// corners of a sample come from one read of each bank in a single cycle. A sample
// result passes the front-end registers, the command queue, the bank read and the blend, scale and
// offset registers to the result queue; writes give no result and are visible to any later sample.
// The rate is set by the single port of each bank and the depths of the command and result queues.
module heightmap_bilinear_sampler_top import hbs_pkg::*; #(
	parameter int MAX_COLS = 256,
	parameter int MAX_ROWS = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  in_item_t            in_item,
	output logic                empty,
	input  logic                pop,
	output out_item_t           out_item,
	input  logic                cfg_wr_en,
	input  cfg_reg_t            cfg_index,
	input  logic [SCALE_W-1:0]  cfg_data
);

	logic [DIM_W-1:0]          map_width_q;
	logic [DIM_W-1:0]          map_height_q;
	logic signed [SCALE_W-1:0] height_scale_q;
	logic signed [SCALE_W-1:0] height_offset_q;

	logic cmd_valid;
	cmd_t cmd_in;
	cmd_t cmd_head;
	logic cmd_empty;
	logic cmd_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q     <= DIM_W'(256);
			map_height_q    <= DIM_W'(256);
			height_scale_q  <= 16'sd256;
			height_offset_q <= 16'sd0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MAP_WIDTH:     map_width_q     <= cfg_data[DIM_W-1:0];
				REG_MAP_HEIGHT:    map_height_q    <= cfg_data[DIM_W-1:0];
				REG_HEIGHT_SCALE:  height_scale_q  <= $signed(cfg_data);
				REG_HEIGHT_OFFSET: height_offset_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	hbs_front #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.in_item    (in_item),
		.map_width  (map_width_q),
		.map_height (map_height_q),
		.issue      (cmd_pop),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd_in)
	);

	hbs_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (MID_DEPTH)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_valid),
		.wr_data (cmd_in),
		.pop     (cmd_pop),
		.rd_data (cmd_head),
		.empty   (cmd_empty)
	);

	hbs_back #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_empty     (cmd_empty),
		.cmd           (cmd_head),
		.cmd_pop       (cmd_pop),
		.height_scale  (height_scale_q),
		.height_offset (height_offset_q),
		.empty         (empty),
		.pop           (pop),
		.out_item      (out_item)
	);

endmodule
